[sv/lcp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_pkg: shared types and constants of the LED command line parser
// Response codes, register indexes, line limits and the command prefix.
// ----------------------------------------------------------------------------
package lcp_pkg;

	localparam int LINE_MAX = 256;
	localparam int POS_W = $clog2(LINE_MAX);
	localparam int DUR_W = 16;
	localparam int TICK_W = 17;
	localparam int LINES = 4;
	localparam int LINE_W = 2;
	localparam int CFG_IDX_W = 1;

	localparam logic [POS_W-1:0] POS_LED = POS_W'(8);
	localparam logic [POS_W-1:0] POS_COMMA = POS_W'(9);
	localparam logic [POS_W-1:0] POS_MIN_OK = POS_W'(11);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_MAX - 1);

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_0 = 8'h30;
	localparam logic [7:0] CH_1 = 8'h31;
	localparam logic [7:0] CH_9 = 8'h39;

	localparam logic [TICK_W-1:0] TICKS_MAX = TICK_W'(65536);

	localparam logic KIND_CHAR = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef enum logic [1:0] {
		RESP_OK  = 2'd0,
		RESP_ERR = 2'd1,
		RESP_OFF = 2'd2
	} resp_t;

	localparam logic [CFG_IDX_W-1:0] REG_LED0 = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_LED1 = CFG_IDX_W'(1);

	// Parse result of the current character against the held line
	typedef struct packed {
		logic             eol;
		logic             overlong;
		logic             ok;
		logic             led_num;
		logic [DUR_W-1:0] dur;
	} lcp_line_t;

	// Request from the item stage to the LED timer
	typedef struct packed {
		logic             step;
		logic             tick;
		logic             arm;
		logic             led_num;
		logic [DUR_W-1:0] dur;
	} lcp_ctl_t;

	// Expiry status from the LED timer
	typedef struct packed {
		logic              expire;
		logic [LINE_W-1:0] id;
		logic [LINES-1:0]  levels;
	} lcp_led_t;

	function automatic logic [7:0] prefix_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = 8'h73; // s
			3'd1: c = 8'h65; // e
			3'd2: c = 8'h74; // t
			3'd3: c = 8'h2D; // -
			3'd4: c = 8'h6C; // l
			3'd5: c = 8'h65; // e
			3'd6: c = 8'h64; // d
			3'd7: c = 8'h20; // space
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[sv/lcp_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_parser: line parser
// Tracks the received line and matches it against "set-led D,MS".
// ----------------------------------------------------------------------------
module lcp_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic [7:0]         rx_byte,
	output lcp_pkg::lcp_line_t line
);

	logic [lcp_pkg::POS_W-1:0] pos_q;
	logic                      bad_q;
	logic                      led_num_q;
	logic [lcp_pkg::DUR_W-1:0] dur_q;
	logic                      ended_q;

	logic                      is_digit;
	logic                      take_bad;
	logic                      take_led;
	logic                      take_dur;
	logic                      take_end;
	logic [lcp_pkg::DUR_W-1:0] dur_next;
	logic [lcp_pkg::DUR_W+3:0] dur_mul;

	assign is_digit = (rx_byte >= lcp_pkg::CH_0) && (rx_byte <= lcp_pkg::CH_9);
	assign dur_mul = ({4'd0, dur_q} << 3) + ({4'd0, dur_q} << 1)
		+ (lcp_pkg::DUR_W + 4)'(rx_byte - lcp_pkg::CH_0);
	assign dur_next = dur_mul[lcp_pkg::DUR_W-1:0];

	always_comb begin
		take_bad = 1'b0;
		take_led = 1'b0;
		take_dur = 1'b0;
		take_end = 1'b0;
		if (!bad_q) begin
			if (pos_q < lcp_pkg::POS_LED) begin
				take_bad = rx_byte != lcp_pkg::prefix_char(pos_q[2:0]);
			end else if (pos_q == lcp_pkg::POS_LED) begin
				take_led = (rx_byte == lcp_pkg::CH_0) || (rx_byte == lcp_pkg::CH_1);
				take_bad = !take_led;
			end else if (pos_q == lcp_pkg::POS_COMMA) begin
				take_bad = rx_byte != lcp_pkg::CH_COMMA;
			end else if (is_digit && !ended_q) begin
				take_dur = 1'b1;
			end else begin
				take_end = 1'b1;
				take_bad = 1'b1;
			end
		end
	end

	always_comb begin
		line.eol = rx_byte == lcp_pkg::CH_CR;
		line.overlong = !line.eol && (pos_q >= lcp_pkg::POS_LAST);
		line.ok = !bad_q && !ended_q && (pos_q >= lcp_pkg::POS_MIN_OK);
		line.led_num = led_num_q;
		line.dur = dur_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			bad_q <= 1'b0;
			led_num_q <= 1'b0;
			dur_q <= '0;
			ended_q <= 1'b0;
		end else if (step) begin
			if (line.eol || line.overlong) begin
				pos_q <= '0;
				bad_q <= 1'b0;
				led_num_q <= 1'b0;
				dur_q <= '0;
				ended_q <= 1'b0;
			end else begin
				pos_q <= pos_q + 1'b1;
				if (take_bad) bad_q <= 1'b1;
				if (take_led) led_num_q <= rx_byte[0];
				if (take_dur) dur_q <= dur_next;
				if (take_end) ended_q <= 1'b1;
			end
		end
	end

endmodule

[sv/lcp_leds.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcp_leds: LED line driver and countdown
// Raises the mapped line on a valid command, dropping the line raised before, and drops it when the timer ends.
// ----------------------------------------------------------------------------
module lcp_leds (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lcp_pkg::lcp_ctl_t          ctl,
	input  logic [lcp_pkg::LINE_W-1:0] led0_line,
	input  logic [lcp_pkg::LINE_W-1:0] led1_line,
	output lcp_pkg::lcp_led_t          led
);

	logic [lcp_pkg::LINE_W:0]   active_q;
	logic [lcp_pkg::TICK_W-1:0] ticks_q;
	logic                       armed_q;
	logic [lcp_pkg::LINES-1:0]  levels_q;

	logic [lcp_pkg::LINES-1:0]  drop_mask;
	logic [lcp_pkg::LINE_W-1:0] target;
	logic [lcp_pkg::DUR_W+6:0]  scaled;
	logic [lcp_pkg::DUR_W+3:0]  ticks_raw;
	logic [lcp_pkg::TICK_W-1:0] ticks_arm;
	logic [lcp_pkg::LINES-1:0]  levels_next;

	assign drop_mask = active_q[lcp_pkg::LINE_W] ? '0
		: (lcp_pkg::LINES)'(1) << active_q[lcp_pkg::LINE_W-1:0];
	assign target = ctl.led_num ? led1_line : led0_line;

	// ms * 125 / 8 rounded up
	assign scaled = ({7'd0, ctl.dur} << 7) - ({7'd0, ctl.dur} << 2) + {7'd0, ctl.dur}
		+ (lcp_pkg::DUR_W + 7)'(7);
	assign ticks_raw = scaled[lcp_pkg::DUR_W+6:3];

	always_comb begin
		if (ticks_raw == '0) begin
			ticks_arm = lcp_pkg::TICK_W'(1);
		end else if (ticks_raw > (lcp_pkg::DUR_W + 4)'(lcp_pkg::TICKS_MAX)) begin
			ticks_arm = lcp_pkg::TICKS_MAX;
		end else begin
			ticks_arm = ticks_raw[lcp_pkg::TICK_W-1:0];
		end
	end

	always_comb begin
		led.expire = ctl.tick && armed_q && (ticks_q == lcp_pkg::TICK_W'(1));
		led.id = active_q[lcp_pkg::LINE_W-1:0];
		levels_next = levels_q;
		if (led.expire) begin
			levels_next = levels_q & ~drop_mask;
		end else if (!ctl.tick && ctl.arm) begin
			levels_next = (levels_q & ~drop_mask) | ((lcp_pkg::LINES)'(1) << target);
		end
		led.levels = levels_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= '0;
			ticks_q <= '0;
			armed_q <= 1'b0;
			levels_q <= '0;
		end else if (ctl.step) begin
			levels_q <= levels_next;
			if (ctl.tick) begin
				if (armed_q) begin
					ticks_q <= ticks_q - 1'b1;
					if (led.expire) begin
						armed_q <= 1'b0;
						active_q <= {1'b1, {lcp_pkg::LINE_W{1'b0}}};
					end
				end
			end else if (ctl.arm) begin
				active_q <= {1'b0, target};
				ticks_q <= ticks_arm;
				armed_q <= 1'b1;
			end
		end
	end

endmodule

[sv/led_command_line_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_command_line_parser: LED command line parser
// Parses "set-led D,MS" lines and drives four timed LED lines.
// ----------------------------------------------------------------------------
// Input beats carry a received character in s_tdata with s_tuser low, or one
// 64 us timer tick with s_tuser high. A CR-terminated line answers OK or
// ERROR on the m_ side, an overlong line ERROR; an expiring countdown
// answers led-off with the line index. Every result carries the current
// levels of the four output lines. Characters inside a line and ticks that
// do not expire give no result. A beat is registered on entry, then decoded
// against the line and timer state into the result register. One beat is
// taken every cycle unless a result stalls. When the receiver stalls, the
// result holds in the output register and beats that give no result keep
// flowing; a beat that gives a result waits in the input register, and
// further input waits until the held result drains.
// Register writes on the cfg_ channel are taken every cycle and map LED 0 and
// LED 1 to output lines; write them only while the block is idle.
// Reset clears the line, stops the countdown, sets all lines low with line 0
// active, and restores the mapping to lines 0 and 1.
// ----------------------------------------------------------------------------
module led_command_line_parser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [7:0]                    s_tdata,   // rx_byte[7:0]
	input  logic                          s_tuser,   // cmd
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [7:0]                    m_tdata,   // resp[1:0], line_id[3:2], led_lines[7:4]
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lcp_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcp_pkg::LINE_W-1:0]    cfg_data
);

	logic                       vld_s1;
	logic                       cmd_s1;
	logic [7:0]                 byte_s1;
	logic                       out_vld_q;
	logic [7:0]                 out_data_q;
	logic [lcp_pkg::LINE_W-1:0] led0_q;
	logic [lcp_pkg::LINE_W-1:0] led1_q;

	lcp_pkg::lcp_line_t line;
	lcp_pkg::lcp_ctl_t  ctl;
	lcp_pkg::lcp_led_t  led;
	lcp_pkg::resp_t     resp;
	logic                       is_tick;
	logic                       has_res;
	logic                       go;
	logic [lcp_pkg::LINE_W-1:0] res_id;

	assign is_tick = cmd_s1 == lcp_pkg::KIND_TICK;
	assign has_res = is_tick ? led.expire : (line.eol || line.overlong);
	assign go = vld_s1 && (!has_res || !out_vld_q || m_tready);
	assign s_tready = !vld_s1 || go;
	assign cfg_ready = 1'b1;
	assign m_tvalid = out_vld_q;
	assign m_tdata = out_data_q;

	always_comb begin
		ctl.step = go;
		ctl.tick = is_tick;
		ctl.arm = line.eol && line.ok;
		ctl.led_num = line.led_num;
		ctl.dur = line.dur;
	end

	always_comb begin
		res_id = '0;
		if (is_tick) begin
			resp = lcp_pkg::RESP_OFF;
			res_id = led.id;
		end else if (line.eol && line.ok) begin
			resp = lcp_pkg::RESP_OK;
		end else begin
			resp = lcp_pkg::RESP_ERR;
		end
	end

	lcp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (go && !is_tick),
		.rx_byte (byte_s1),
		.line    (line)
	);

	lcp_leds u_leds (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.led0_line (led0_q),
		.led1_line (led1_q),
		.led       (led)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led0_q <= lcp_pkg::LINE_W'(0);
			led1_q <= lcp_pkg::LINE_W'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				lcp_pkg::REG_LED0: led0_q <= cfg_data;
				lcp_pkg::REG_LED1: led1_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			cmd_s1 <= s_tuser;
			byte_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (go && has_res) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && has_res) begin
			out_data_q <= {led.levels, res_id, resp};
		end
	end

endmodule
